// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also evaluated while reset is asserted
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ckm_pkg.sv =====
package ckm_pkg;

  localparam int KW_COUNT   = 21;
  localparam int KW_LEN_MAX = 18;
  localparam int POS_W      = 5;
  localparam int CODE_W     = 5;

  localparam logic [POS_W-1:0]  POS_MAX            = 5'd31;
  localparam logic [CODE_W-1:0] CODE_UNIDENTIFIED  = 5'd0;
  localparam logic [CODE_W-1:0] CODE_CHAT          = 5'd1;
  localparam logic [CODE_W-1:0] CODE_FIRST_KEYWORD = 5'd2;
  localparam logic [7:0]        CHAR_CHAT          = 8'h3C;

  // keyword text, right-justified in each entry
  localparam logic [KW_LEN_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
    "$MyINFO ",
    "$MyPass ",
    "$MyNick ",
    "$MultiSearch ",
    "$MultiConnectToMe ",
    "$Search ",
    "$SR ",
    "$Supports ",
    "$Lock ",
    "$Key ",
    "$Kick ",
    "$Hello ",
    "$GetINFO ",
    "$GetNickList",
    "$ConnectToMe ",
    "$RevConnectToMe ",
    "$To: ",
    "$Quit ",
    "$OpForceMove ",
    "$ValidateNick ",
    "$BotINFO"
  };

  localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
    5'd8, 5'd8, 5'd8, 5'd13, 5'd18, 5'd8, 5'd4, 5'd10, 5'd6, 5'd5, 5'd6,
    5'd7, 5'd9, 5'd12, 5'd13, 5'd16, 5'd5, 5'd6, 5'd13, 5'd14, 5'd8
  };

  // per-line match state
  typedef struct packed {
    logic [KW_COUNT-1:0] live;
    logic [POS_W-1:0]    pos;
    logic                decided;
  } match_state_t;

  // classification result of one word
  typedef struct packed {
    logic              emit;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  offset;
  } match_res_t;

  // character of keyword k at position pos (pos below the keyword length)
  function automatic logic [7:0] kw_byte(input int k, input logic [POS_W-1:0] pos);
    int idx;
    logic [7:0] ch;
    idx = int'(KW_LEN[k]) - 1 - int'(pos);
    ch  = 8'h00;
    if (idx >= 0) begin
      ch = KW_TEXT[k][idx*8 +: 8];
    end
    return ch;
  endfunction

endpackage

// ===== src/ckm_match.sv =====
module ckm_match (
  input  ckm_pkg::match_state_t st,
  input  logic [7:0]            line_byte,
  input  logic                  end_of_line,
  output ckm_pkg::match_state_t st_nxt,
  output ckm_pkg::match_res_t   res
);

  logic [ckm_pkg::KW_COUNT-1:0]  hit;
  logic                          found;
  logic [ckm_pkg::CODE_W-1:0]    found_code;
  logic [ckm_pkg::POS_W-1:0]     found_len;

  // column compare of every live keyword against this byte
  always_comb begin
    hit        = '0;
    found      = 1'b0;
    found_code = ckm_pkg::CODE_UNIDENTIFIED;
    found_len  = '0;
    for (int k = ckm_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (st.live[k] && (st.pos < ckm_pkg::KW_LEN[k]) &&
          (ckm_pkg::kw_byte(k, st.pos) == line_byte)) begin
        hit[k] = 1'b1;
        if (st.pos + 5'd1 == ckm_pkg::KW_LEN[k]) begin
          // lowest index wins
          found      = 1'b1;
          found_code = ckm_pkg::CODE_FIRST_KEYWORD + ckm_pkg::CODE_W'(k);
          found_len  = ckm_pkg::KW_LEN[k];
        end
      end
    end
  end

  // next state and result
  always_comb begin
    st_nxt     = st;
    res.emit   = 1'b0;
    res.code   = ckm_pkg::CODE_UNIDENTIFIED;
    res.offset = '0;
    if (end_of_line) begin
      // line closed: report if still open, then restart
      res.emit       = !st.decided;
      st_nxt.live    = {ckm_pkg::KW_COUNT{1'b1}};
      st_nxt.pos     = '0;
      st_nxt.decided = 1'b0;
    end else if (st.decided) begin
      // rest of a decided line is dropped
    end else if ((st.pos == '0) && (line_byte == ckm_pkg::CHAR_CHAT)) begin
      res.emit       = 1'b1;
      res.code       = ckm_pkg::CODE_CHAT;
      st_nxt.decided = 1'b1;
    end else begin
      st_nxt.live = hit;
      st_nxt.pos  = (st.pos == ckm_pkg::POS_MAX) ? st.pos : st.pos + 5'd1;
      if (found) begin
        res.emit   = 1'b1;
        res.code   = found_code;
        res.offset = found_len;
      end else if (hit == '0) begin
        res.emit = 1'b1;
      end
      st_nxt.decided = res.emit;
    end
  end

endmodule

// ===== src/command_keyword_matcher.sv =====
// Command keyword matcher.
// Input channel (in_*): one word per line character, in_tdata[7:0] holds the
// byte; a word with in_tlast high closes the line and its data is ignored.
// Output channel (out_*): at most one word per line, giving the token code
// (0 unidentified, 1 chat, 2.. keyword) and the byte offset of the argument.
// A line is decided on the byte that completes a keyword, on a leading '<',
// on the byte that leaves no keyword candidate, or at line end; later bytes
// of that line give nothing.
// A result leaves through the input register, then the result register,
// after the word that decides it is accepted.
// Throughput: one word per cycle unless out_tready low stalls the output;
// the keyword compare is a single column compare per byte on the keyword table.
// Reset (rst_n low, synchronous) empties both registers and starts a fresh
// line. When the receiver holds out_tready low, the result register holds
// its word and the input register fills; in_tready falls only once both
// are occupied.
`include "assert_macros.svh"

module command_keyword_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_byte
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [4:0] token_code, [9:5] argument_offset
);

  logic                      s1_valid_r;
  logic [7:0]                s1_byte_r;
  logic                      s1_eol_r;
  ckm_pkg::match_state_t     st_r;
  ckm_pkg::match_state_t     st_nxt;
  ckm_pkg::match_res_t       res;
  logic                      out_valid_r;
  logic [ckm_pkg::CODE_W-1:0] out_code_r;
  logic [ckm_pkg::POS_W-1:0]  out_off_r;
  logic                      out_free;
  logic                      s1_adv;
  logic                      chk_live_any;
  logic                      chk_eol_adv;
  logic                      chk_fresh;
  logic                      chk_late_adv;
  logic                      chk_out_unid;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_eol_r  <= in_tlast;
    end
  end

  ckm_match u_match (
    .st          (st_r),
    .line_byte   (s1_byte_r),
    .end_of_line (s1_eol_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.live    <= {ckm_pkg::KW_COUNT{1'b1}};
      st_r.pos     <= '0;
      st_r.decided <= 1'b0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_code_r <= res.code;
      out_off_r  <= res.offset;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_off_r, out_code_r};

  // terms for the checks
  assign chk_live_any = (st_r.live != '0);
  assign chk_eol_adv  = s1_adv && s1_eol_r;
  assign chk_fresh    = (st_r.live == {ckm_pkg::KW_COUNT{1'b1}}) && (st_r.pos == '0) &&
                        !st_r.decided;
  assign chk_late_adv = s1_adv && st_r.decided && !s1_eol_r;
  assign chk_out_unid = out_valid_r && (out_code_r == ckm_pkg::CODE_UNIDENTIFIED);

  // checks
  `ASSERT_CLK(a_open_line_has_live, !st_r.decided |-> chk_live_any, "open line with no candidate")
  `ASSERT_CLK(a_eol_restarts, chk_eol_adv |=> chk_fresh, "line end did not restart")
  `ASSERT_CLK(a_no_emit_decided, chk_late_adv |-> !res.emit, "result on decided line")
  `ASSERT_CLK(a_unid_zero_off, chk_out_unid |-> (out_off_r == '0), "unidentified with offset")

endmodule
